// ===== rtl/ccps_pkg.sv =====
// shared types, constants and helpers for the character class pattern scanner
package ccps_pkg;

    localparam int PATTERN_MAX = 32;
    localparam int INNER_MAX   = PATTERN_MAX - 2;
    localparam int IDX_W       = $clog2(PATTERN_MAX);
    localparam int LEN_W       = 6;
    localparam int CLASSES_W   = 64;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [LEN_W-1:0] LEN_MIN = LEN_W'(3);
    localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(PATTERN_MAX);
    localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(13);

    localparam logic REG_PATTERN_CLASSES = 1'b0;
    localparam logic REG_PATTERN_LENGTH  = 1'b1;

    localparam logic [1:0] CLASS_OTHER  = 2'd0;
    localparam logic [1:0] CLASS_DIGIT  = 2'd1;
    localparam logic [1:0] CLASS_HYPHEN = 2'd2;

    localparam logic [7:0] CHAR_ZERO   = 8'h30;
    localparam logic [7:0] CHAR_NINE   = 8'h39;
    localparam logic [7:0] CHAR_HYPHEN = 8'h2D;

    typedef logic [7:0] byte_t;

    typedef struct packed {
        byte_t [INNER_MAX-1:0] bytes;
        logic [IDX_W-1:0]      first_idx;
    } ccps_entry_t;

    function automatic logic [1:0] class_of(input byte_t b);
        logic [1:0] c;
        if (b >= CHAR_ZERO && b <= CHAR_NINE)
        begin
            c = CLASS_DIGIT;
        end
        else if (b == CHAR_HYPHEN)
        begin
            c = CLASS_HYPHEN;
        end
        else
        begin
            c = CLASS_OTHER;
        end
        return c;
    endfunction

endpackage

// ===== rtl/ccps_front.sv =====
// front end: config registers, byte history, class compare and match capture
module ccps_front
    import ccps_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_write_en,
    input  logic                 cfg_index,
    input  logic [CLASSES_W-1:0] cfg_data,
    input  logic                 accept,
    input  byte_t                data_byte,
    input  logic                 end_of_file,
    output logic                 push,
    output ccps_entry_t          push_entry
);

    logic [CLASSES_W-1:0]        classes_reg;
    logic [LEN_W-1:0]            length_reg;
    byte_t [PATTERN_MAX-1:0]     hist_reg;
    byte_t [PATTERN_MAX-1:0]     hist_next;
    logic [LEN_W-1:0]            seen_reg;
    logic [LEN_W-1:0]            seen_next;
    logic [LEN_W-1:0]            eff_len;
    logic [IDX_W-1:0]            len_m1;
    logic [PATTERN_MAX-1:0]      pos_ok;
    logic [IDX_W-1:0]            pos [PATTERN_MAX];
    logic                        match;

    // clamp configured length into the supported range
    always_comb
    begin
        if (length_reg < LEN_MIN)
        begin
            eff_len = LEN_MIN;
        end
        else if (length_reg > LEN_MAX)
        begin
            eff_len = LEN_MAX;
        end
        else
        begin
            eff_len = length_reg;
        end
        len_m1 = IDX_W'(eff_len - LEN_W'(1));
    end

    always_comb
    begin
        hist_next[0] = data_byte;
        for (int i = 1; i < PATTERN_MAX; i++)
        begin
            hist_next[i] = hist_reg[i-1];
        end
        seen_next = (seen_reg < LEN_MAX) ? seen_reg + LEN_W'(1) : seen_reg;
    end

    // window slot i (newest first) lines up with pattern position len-1-i
    always_comb
    begin
        for (int i = 0; i < PATTERN_MAX; i++)
        begin
            pos[i] = len_m1 - IDX_W'(i);
            if (IDX_W'(i) > len_m1)
            begin
                pos_ok[i] = 1'b1;
            end
            else
            begin
                pos_ok[i] = class_of(hist_next[i]) == classes_reg[{pos[i], 1'b0} +: 2];
            end
        end
        match = (&pos_ok) && (seen_next >= eff_len);
    end

    assign push = accept && match;

    always_comb
    begin
        for (int j = 0; j < INNER_MAX; j++)
        begin
            push_entry.bytes[j] = hist_next[j+1];
        end
        push_entry.first_idx = len_m1 - IDX_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            classes_reg <= '0;
            length_reg  <= LEN_RESET;
        end
        else if (cfg_write_en)
        begin
            unique case (cfg_index)
                REG_PATTERN_CLASSES: classes_reg <= cfg_data;
                REG_PATTERN_LENGTH:  length_reg  <= cfg_data[LEN_W-1:0];
                default:             classes_reg <= classes_reg;
            endcase
        end
    end

    // history clears after the last byte of a file
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hist_reg <= '0;
            seen_reg <= '0;
        end
        else if (accept)
        begin
            if (end_of_file)
            begin
                hist_reg <= '0;
                seen_reg <= '0;
            end
            else
            begin
                hist_reg <= hist_next;
                seen_reg <= seen_next;
            end
        end
    end

endmodule

// ===== rtl/ccps_queue.sv =====
// short queue of captured matches between front and back
module ccps_queue
    import ccps_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  ccps_entry_t push_entry,
    input  logic        pop,
    output logic        full,
    output logic        head_valid,
    output ccps_entry_t head
);

    ccps_entry_t       mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;

    assign full       = count_reg == QCNT_W'(QUEUE_DEPTH);
    assign head_valid = count_reg != '0;
    assign head       = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + QCNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                       : wr_ptr_reg + QPTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                       : rd_ptr_reg + QPTR_W'(1);
            end
        end
    end

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("match captured while queue full");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head_valid)
        else $error("queue popped while empty");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue count out of range");

    a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> count_reg == $past(count_reg) + QCNT_W'(1))
        else $error("queue count did not follow a push");

endmodule

// ===== rtl/ccps_back.sv =====
// back end: walks the head match and emits its inner bytes oldest first
module ccps_back
    import ccps_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        head_valid,
    input  ccps_entry_t head,
    output logic        pop,
    input  logic        out_stall,
    output logic        out_valid,
    output byte_t       match_byte,
    output logic        match_last
);

    logic [IDX_W-1:0] step_reg;
    logic [IDX_W-1:0] idx;
    logic [IDX_W-1:0] sel;
    logic             load;
    logic             out_valid_reg;
    byte_t            match_byte_reg;
    logic             match_last_reg;

    assign idx  = head.first_idx - step_reg;
    assign sel  = idx - IDX_W'(1);
    assign load = head_valid && (!out_valid_reg || !out_stall);
    assign pop  = load && (idx == IDX_W'(1));

    assign out_valid  = out_valid_reg;
    assign match_byte = match_byte_reg;
    assign match_last = match_last_reg;

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            match_byte_reg <= head.bytes[sel];
            match_last_reg <= idx == IDX_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            step_reg      <= '0;
        end
        else
        begin
            if (load)
            begin
                out_valid_reg <= 1'b1;
                step_reg      <= pop ? '0 : step_reg + IDX_W'(1);
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

// ===== rtl/char_class_pattern_scanner.sv =====
// top level of the character class pattern scanner
// Takes one byte per cycle and compares the classes (digit, hyphen, other) of the
// newest pattern_length bytes of the current file with the configured class pattern.
// A match is captured whole in the cycle its last byte is taken and parked in a
// four-entry queue; the emitter then sends its inner bytes, oldest first, one per
// cycle while out_stall is low, with match_last on the final one. The first result
// passes the queue and then the output register. A match of length n gives n-2 bytes,
// so the input keeps one byte per cycle unless matches arrive faster than the emitter
// drains them; in_stall rises only while all four queue entries are taken.
module char_class_pattern_scanner
    import ccps_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_write_en,
    input  logic                 cfg_index,
    input  logic [CLASSES_W-1:0] cfg_data,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [7:0]           data_byte,
    input  logic                 end_of_file,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [7:0]           match_byte,
    output logic                 match_last
);

    logic        accept;
    logic        push;
    logic        pop;
    logic        full;
    logic        head_valid;
    ccps_entry_t push_entry;
    ccps_entry_t head;

    assign in_stall = full;
    assign accept   = in_valid && !in_stall;

    ccps_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .accept       (accept),
        .data_byte    (data_byte),
        .end_of_file  (end_of_file),
        .push         (push),
        .push_entry   (push_entry)
    );

    ccps_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .full       (full),
        .head_valid (head_valid),
        .head       (head)
    );

    ccps_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .out_stall  (out_stall),
        .out_valid  (out_valid),
        .match_byte (match_byte),
        .match_last (match_last)
    );

endmodule

// ===== test/char_class_pattern_scanner_test.sv =====
// testbench for the character class pattern scanner: directed table, random windows, predictor
module char_class_pattern_scanner_test;
    timeunit 1ns;
    timeprecision 1ps;

    import ccps_pkg::*;

    localparam int CYCLE_LIMIT = 300000;
    localparam int SETTLE_CYCLES = 8;
    localparam int REPORT_MAX = 10;
    localparam logic [CLASSES_W-1:0] ALL_UNUSED = {CLASSES_W{1'b1}};
    localparam logic [1:0] CLASS_UNUSED = 2'd3;

    typedef struct packed {
        byte_t mbyte;
        logic  mlast;
    } match_t;

    typedef enum logic [1:0] { ROW_WRITE, ROW_QUIET, ROW_SINGLE, ROW_MODEL } row_kind_t;

    typedef struct packed {
        row_kind_t            kind;
        logic                 idx;
        logic [CLASSES_W-1:0] value;
        byte_t                data;
        logic                 eof;
        byte_t                want;
    } stim_row_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_write_en = 1'b0;
    logic                 cfg_index = 1'b0;
    logic [CLASSES_W-1:0] cfg_data = '0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    logic [7:0]           data_byte = '0;
    logic                 end_of_file = 1'b0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic [7:0]           match_byte;
    logic                 match_last;

    int unsigned cycle_count = 0;
    int errors = 0;
    int send_idle_pct = 0;
    int stall_pct = 0;

    match_t    pending_matches[$];
    stim_row_t directed_rows[$];

    // predictor state
    byte_t                history[PATTERN_MAX];
    int                   held = 0;
    logic [CLASSES_W-1:0] classes_reg = '0;
    logic [LEN_W-1:0]     length_reg = LEN_RESET;

    char_class_pattern_scanner u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .data_byte    (data_byte),
        .end_of_file  (end_of_file),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .match_byte   (match_byte),
        .match_last   (match_last)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("char_class_pattern_scanner verification failed");
            $finish;
        end
    end

    function automatic logic [1:0] byte_class(input byte_t b);
        logic [1:0] c;
        c = CLASS_OTHER;
        if (b >= CHAR_ZERO && b <= CHAR_NINE)
        begin
            c = CLASS_DIGIT;
        end
        else if (b == CHAR_HYPHEN)
        begin
            c = CLASS_HYPHEN;
        end
        return c;
    endfunction

    function automatic int window_length();
        int len;
        len = int'(length_reg);
        if (len < int'(LEN_MIN))
        begin
            len = int'(LEN_MIN);
        end
        if (len > int'(LEN_MAX))
        begin
            len = int'(LEN_MAX);
        end
        return len;
    endfunction

    function automatic int scan_byte(input byte_t b, input logic eof,
                                     output match_t found[INNER_MAX]);
        int len;
        int count;
        int p;
        logic hit;
        len = window_length();
        count = 0;
        for (p = PATTERN_MAX - 1; p > 0; p--)
        begin
            history[p] = history[p-1];
        end
        history[0] = b;
        if (held < PATTERN_MAX)
        begin
            held++;
        end
        if (held >= len)
        begin
            hit = 1'b1;
            for (p = 0; p < len; p++)
            begin
                if (byte_class(history[len-1-p]) != classes_reg[2*p +: 2])
                begin
                    hit = 1'b0;
                end
            end
            if (hit)
            begin
                for (p = 1; p < len - 1; p++)
                begin
                    found[count].mbyte = history[len-1-p];
                    found[count].mlast = (p == len - 2);
                    count++;
                end
            end
        end
        if (eof)
        begin
            for (p = 0; p < PATTERN_MAX; p++)
            begin
                history[p] = '0;
            end
            held = 0;
        end
        return count;
    endfunction

    function automatic byte_t byte_of_class(input logic [1:0] code);
        byte_t b;
        b = '0;
        case (code)
            CLASS_DIGIT:  b = CHAR_ZERO + byte_t'($urandom_range(0, 9));
            CLASS_HYPHEN: b = CHAR_HYPHEN;
            CLASS_OTHER:
            begin
                do
                begin
                    b = byte_t'($urandom_range(0, 255));
                end
                while (byte_class(b) != CLASS_OTHER);
            end
            default:      b = byte_t'($urandom_range(0, 255));
        endcase
        return b;
    endfunction

    function automatic logic [CLASSES_W-1:0] random_pattern(input int top_code);
        logic [CLASSES_W-1:0] c;
        int p;
        c = '0;
        for (p = 0; p < PATTERN_MAX; p++)
        begin
            c[2*p +: 2] = 2'($urandom_range(0, top_code));
        end
        return c;
    endfunction

    task automatic drive_byte(input byte_t b, input logic eof);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        data_byte <= b;
        end_of_file <= eof;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
    endtask

    task automatic feed_byte(input byte_t b, input logic eof);
        match_t found[INNER_MAX];
        int n;
        int i;
        n = scan_byte(b, eof, found);
        for (i = 0; i < n; i++)
        begin
            pending_matches.push_back(found[i]);
        end
        drive_byte(b, eof);
    endtask

    task automatic write_reg(input logic idx, input logic [CLASSES_W-1:0] value);
        in_valid <= 1'b0;
        while (pending_matches.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_write_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_write_en <= 1'b0;
        if (idx == REG_PATTERN_CLASSES)
        begin
            classes_reg = value;
        end
        else
        begin
            length_reg = value[LEN_W-1:0];
        end
    endtask

    task automatic add_write(input logic idx, input logic [CLASSES_W-1:0] value);
        stim_row_t row;
        row = '{ROW_WRITE, idx, value, 8'h00, 1'b0, 8'h00};
        directed_rows.push_back(row);
    endtask

    task automatic add_byte(input row_kind_t kind, input byte_t data, input logic eof,
                            input byte_t want);
        stim_row_t row;
        row = '{kind, 1'b0, '0, data, eof, want};
        directed_rows.push_back(row);
    endtask

    task automatic run_phase(input logic [LEN_W-1:0] len_value,
                             input logic [CLASSES_W-1:0] pattern, input int items);
        byte_t window[PATTERN_MAX];
        logic [1:0] code;
        int span;
        int n;
        int p;
        int r;
        int k;
        int sent;
        write_reg(REG_PATTERN_LENGTH, CLASSES_W'(len_value));
        write_reg(REG_PATTERN_CLASSES, pattern);
        span = window_length();
        sent = 0;
        while (sent < items)
        begin
            r = $urandom_range(0, 99);
            if (r < 85)
            begin
                // well-formed window, broken at one position now and then
                n = span;
                for (p = 0; p < span; p++)
                begin
                    window[p] = byte_of_class(classes_reg[2*p +: 2]);
                end
                if (r >= 70)
                begin
                    k = $urandom_range(0, span - 1);
                    code = classes_reg[2*k +: 2];
                    if (code != CLASS_UNUSED)
                    begin
                        window[k] = byte_of_class(2'((int'(code) + $urandom_range(1, 2)) % 3));
                    end
                end
            end
            else
            begin
                n = $urandom_range(1, 4);
                for (p = 0; p < n; p++)
                begin
                    window[p] = byte_t'($urandom_range(0, 255));
                end
            end
            for (p = 0; p < n && sent < items; p++)
            begin
                feed_byte(window[p], ($urandom_range(0, 39) == 0));
                sent++;
            end
        end
    endtask

    // result checker and receiver stall
    initial
    begin
        match_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
            begin
                if (pending_matches.size() == 0)
                begin
                    errors++;
                    if (errors <= REPORT_MAX)
                    begin
                        $display("unexpected result: match_byte %h match_last %b",
                                 match_byte, match_last);
                    end
                end
                else
                begin
                    want = pending_matches.pop_front();
                    if (match_byte !== want.mbyte || match_last !== want.mlast)
                    begin
                        errors++;
                        if (errors <= REPORT_MAX)
                        begin
                            $display("mismatch: match_byte %h/%h match_last %b/%b (exp/act)",
                                     want.mbyte, match_byte, want.mlast, match_last);
                        end
                    end
                end
            end
            out_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    initial
    begin
        stim_row_t row;
        match_t found[INNER_MAX];
        match_t single;
        int n;
        int i;
        int ph;

        for (i = 0; i < PATTERN_MAX; i++)
        begin
            history[i] = '0;
        end

        // reset pattern, file too short to match
        add_byte(ROW_QUIET, 8'h00, 1'b0, 8'h00);
        add_byte(ROW_QUIET, 8'hFF, 1'b0, 8'h00);
        add_byte(ROW_QUIET, CHAR_ZERO, 1'b0, 8'h00);
        add_byte(ROW_QUIET, CHAR_NINE, 1'b0, 8'h00);
        add_byte(ROW_QUIET, CHAR_HYPHEN, 1'b1, 8'h00);
        // length below range, digit hyphen digit
        add_write(REG_PATTERN_LENGTH, '0);
        add_write(REG_PATTERN_CLASSES, CLASSES_W'(64'h19));
        add_byte(ROW_QUIET, "0", 1'b0, 8'h00);
        add_byte(ROW_QUIET, "-", 1'b0, 8'h00);
        add_byte(ROW_SINGLE, "9", 1'b0, "-");
        add_byte(ROW_QUIET, "-", 1'b0, 8'h00);
        add_byte(ROW_SINGLE, "0", 1'b0, "-");
        add_byte(ROW_QUIET, 8'h2F, 1'b0, 8'h00);
        add_byte(ROW_QUIET, 8'h3A, 1'b0, 8'h00);
        add_byte(ROW_QUIET, 8'h2C, 1'b0, 8'h00);
        add_byte(ROW_QUIET, "7", 1'b1, 8'h00);
        add_byte(ROW_QUIET, "-", 1'b0, 8'h00);
        add_byte(ROW_QUIET, "3", 1'b0, 8'h00);
        add_byte(ROW_QUIET, "-", 1'b0, 8'h00);
        add_byte(ROW_SINGLE, "8", 1'b1, "-");
        // length above range, unused class code everywhere
        add_write(REG_PATTERN_LENGTH, CLASSES_W'(63));
        add_write(REG_PATTERN_CLASSES, ALL_UNUSED);
        add_byte(ROW_MODEL, 8'h80, 1'b0, 8'h00);
        add_byte(ROW_MODEL, 8'h7F, 1'b0, 8'h00);
        add_byte(ROW_MODEL, "-", 1'b0, 8'h00);
        add_byte(ROW_MODEL, "5", 1'b1, 8'h00);

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            row = directed_rows[i];
            case (row.kind)
                ROW_WRITE:
                begin
                    write_reg(row.idx, row.value);
                end
                ROW_QUIET:
                begin
                    n = scan_byte(row.data, row.eof, found);
                    drive_byte(row.data, row.eof);
                end
                ROW_SINGLE:
                begin
                    n = scan_byte(row.data, row.eof, found);
                    single.mbyte = row.want;
                    single.mlast = 1'b1;
                    pending_matches.push_back(single);
                    drive_byte(row.data, row.eof);
                end
                default:
                begin
                    feed_byte(row.data, row.eof);
                end
            endcase
        end

        for (ph = 0; ph < 9; ph++)
        begin
            case (ph % 4)
                0:       begin send_idle_pct = 0;  stall_pct = 0;  end
                1:       begin send_idle_pct = 63; stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  stall_pct = 63; end
                default: begin send_idle_pct = 37; stall_pct = 37; end
            endcase
            case (ph)
                0:       run_phase(LEN_W'(3), random_pattern(2), 40);
                1:       run_phase(LEN_W'(32), '0, 40);
                2:       run_phase(LEN_W'(13), random_pattern(2), 40);
                3:       run_phase(LEN_W'(63), random_pattern(2), 40);
                4:       run_phase(LEN_W'(1), random_pattern(2), 40);
                5:       run_phase(LEN_W'($urandom_range(3, 32)), random_pattern(3), 40);
                6:       run_phase(LEN_W'(2), ALL_UNUSED, 30);
                7:       run_phase(LEN_W'($urandom_range(3, 10)), random_pattern(2), 40);
                default: run_phase(LEN_W'(31), random_pattern(2), 40);
            endcase
        end

        in_valid <= 1'b0;
        while (pending_matches.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (20) @(posedge clk);

        if (errors == 0)
        begin
            $display("char_class_pattern_scanner verification clean");
        end
        else
        begin
            $display("char_class_pattern_scanner verification failed");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/ccps_pkg.sv
rtl/ccps_front.sv
rtl/ccps_queue.sv
rtl/ccps_back.sv
rtl/char_class_pattern_scanner.sv
test/char_class_pattern_scanner_test.sv
